FILE: design/mbb_pkg.sv
// shared types and constants for the monochrome bitmap blit block
package mbb_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int BANK_AW     = 9;
    localparam int BANK_DEPTH  = 512;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_SRC   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic [9:0]         blit_width;
    } blit_geom_t;

    typedef struct packed {
        logic        valid;
        op_t         op;
        logic        done;
        logic [7:0]  data;
        logic [7:0]  col_byte;
        logic [9:0]  row;
        logic [ADDR_W-1:0] addr;
    } s1_t;

    typedef struct packed {
        logic              we;
        logic [BANK_AW-1:0] idx;
        logic [7:0]        mask;
        logic [7:0]        data;
    } bank_wr_t;

    typedef struct packed {
        logic     valid;
        op_t      op;
        logic     done;
        logic     rd_bank;
        bank_wr_t even;
        bank_wr_t odd;
    } s2_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       blit_done;
    } result_t;

endpackage

FILE: design/mono_bitmap_clipped_blit_top.sv
// top level of the clipped 1 bpp bitmap blit into a packed byte framebuffer
//
// clipped monochrome blit engine. cmd 0 starts a blit (position, size, row
// pitch, color where 0 inverts), cmd 1 streams source bytes row by row msb
// first, cmd 2 reads one framebuffer byte, cmd 3 is ignored. a read returns
// one item with the byte; the last source byte of a blit returns one item with
// blit_done set; everything else returns nothing. the framebuffer is split into
// even and odd byte banks, so the two bytes a source byte can touch are
// updated together: the block takes one item per clock while in_ready is
// high, and a result passes the input stage, the merge stage and the
// output queue. throughput is set by the two-stage read-modify-write through
// the banks, which forward a write to a read of the same byte in the next
// cycle. up to four results queue at the output; in_ready drops when the
// queue plus results in flight would overflow. after reset a clearing pass
// zeroes both banks, during which in_ready stays low.
module mono_bitmap_clipped_blit_top #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [10:0] pos_x,
    input  logic signed [10:0] pos_y,
    input  logic [9:0]         width,
    input  logic [9:0]         height,
    input  logic [7:0]         row_bytes,
    input  logic               fg_color,
    input  logic [7:0]         src_byte,
    input  logic [9:0]         fb_addr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data,
    output logic               blit_done
);
    import mbb_pkg::*;

    logic                 accept;
    blit_geom_t           geom;
    s1_t                  s1;
    s2_t                  s2;
    logic [BANK_AW-1:0]   rd_idx_even;
    logic [BANK_AW-1:0]   rd_idx_odd;
    logic [7:0]           rd_even;
    logic [7:0]           rd_odd;

    // clearing pass counter, top bit set once every bank row is zeroed
    logic [BANK_AW:0]     clr_cnt_reg, clr_cnt_next;
    logic                 clearing;

    logic                 we_even, we_odd;
    logic [BANK_AW-1:0]   waddr_even, waddr_odd;
    logic [7:0]           wdata_even, wdata_odd;

    logic                 s1_res, s2_res;
    logic [FIFO_CW:0]     occupancy;
    logic                 push, pop;
    result_t              push_data;
    result_t              head;
    logic [FIFO_CW-1:0]   fifo_count;

    assign clearing     = !clr_cnt_reg[BANK_AW];
    assign clr_cnt_next = clearing ? clr_cnt_reg + (BANK_AW+1)'(1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // results already committed ahead of the queue
    assign s1_res    = s1.valid && ((s1.op == OP_READ) || s1.done);
    assign s2_res    = s2.valid && ((s2.op == OP_READ) || s2.done);
    assign occupancy = {1'b0, fifo_count} + (FIFO_CW+1)'(s1_res) + (FIFO_CW+1)'(s2_res);
    assign in_ready  = !clearing && (occupancy < (FIFO_CW+1)'(FIFO_DEPTH));
    assign accept    = in_valid && in_ready;

    mbb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .width     (width),
        .height    (height),
        .row_bytes (row_bytes),
        .fg_color  (fg_color),
        .src_byte  (src_byte),
        .fb_addr   (fb_addr),
        .geom      (geom),
        .s1        (s1)
    );

    mbb_place #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_place (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .s1          (s1),
        .rd_idx_even (rd_idx_even),
        .rd_idx_odd  (rd_idx_odd),
        .s2          (s2)
    );

    // merge: masked bits come from the source, the rest from the stored byte
    always_comb
    begin
        if (clearing)
        begin
            we_even    = 1'b1;
            we_odd     = 1'b1;
            waddr_even = clr_cnt_reg[BANK_AW-1:0];
            waddr_odd  = clr_cnt_reg[BANK_AW-1:0];
            wdata_even = 8'h00;
            wdata_odd  = 8'h00;
        end
        else
        begin
            we_even    = s2.valid && (s2.op == OP_WRITE) && s2.even.we;
            we_odd     = s2.valid && (s2.op == OP_WRITE) && s2.odd.we;
            waddr_even = s2.even.idx;
            waddr_odd  = s2.odd.idx;
            wdata_even = (rd_even & ~s2.even.mask) | (s2.even.data & s2.even.mask);
            wdata_odd  = (rd_odd  & ~s2.odd.mask)  | (s2.odd.data  & s2.odd.mask);
        end
    end

    mbb_bank u_bank_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (waddr_even),
        .wdata (wdata_even),
        .raddr (rd_idx_even),
        .rdata (rd_even)
    );

    mbb_bank u_bank_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (waddr_odd),
        .wdata (wdata_odd),
        .raddr (rd_idx_odd),
        .rdata (rd_odd)
    );

    // done items carry a zero byte
    always_comb
    begin
        push                = s2_res;
        push_data.blit_done = s2.done;
        if (s2.op == OP_READ)
        begin
            push_data.read_data = s2.rd_bank ? rd_odd : rd_even;
        end
        else
        begin
            push_data.read_data = 8'h00;
        end
    end

    assign pop = out_valid && out_ready;

    mbb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (fifo_count)
    );

    assign out_valid = (fifo_count != '0);
    assign read_data = head.read_data;
    assign blit_done = head.blit_done;

endmodule

FILE: design/mbb_bank.sv
// one framebuffer bank, single write port, registered write-first read port
module mbb_bank (
    input  logic                        clk,
    input  logic                        we,
    input  logic [mbb_pkg::BANK_AW-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic [mbb_pkg::BANK_AW-1:0] raddr,
    output logic [7:0]                  rdata
);
    import mbb_pkg::*;

    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // same-cycle write to the read address returns the new byte
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mbb_seq.sv
// command decode, blit sequencing state and the input stage register
module mbb_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          cmd,
    input  logic signed [10:0]  pos_x,
    input  logic signed [10:0]  pos_y,
    input  logic [9:0]          width,
    input  logic [9:0]          height,
    input  logic [7:0]          row_bytes,
    input  logic                fg_color,
    input  logic [7:0]          src_byte,
    input  logic [9:0]          fb_addr,
    output mbb_pkg::blit_geom_t geom,
    output mbb_pkg::s1_t        s1
);
    import mbb_pkg::*;

    logic signed [10:0] origin_x_reg, origin_x_next;
    logic signed [10:0] origin_y_reg, origin_y_next;
    logic [9:0]         blit_width_reg, blit_width_next;
    logic [9:0]         blit_height_reg, blit_height_next;
    logic [7:0]         pitch_reg, pitch_next;
    logic               invert_reg, invert_next;
    logic [9:0]         row_reg, row_next;
    logic [7:0]         col_byte_reg, col_byte_next;
    s1_t                s1_reg, s1_next;

    always_comb
    begin
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        blit_width_next  = blit_width_reg;
        blit_height_next = blit_height_reg;
        pitch_next       = pitch_reg;
        invert_next      = invert_reg;
        row_next         = row_reg;
        col_byte_next    = col_byte_reg;
        s1_next          = s1_reg;
        s1_next.valid    = 1'b0;
        if (accept)
        begin
            case (cmd)
                CMD_BEGIN:
                begin
                    origin_x_next    = pos_x;
                    origin_y_next    = pos_y;
                    blit_width_next  = width;
                    blit_height_next = height;
                    pitch_next       = (row_bytes == 8'd0) ? 8'd1 : row_bytes;
                    invert_next      = ~fg_color;
                    row_next         = 10'd0;
                    col_byte_next    = 8'd0;
                end
                CMD_SRC:
                begin
                    // source bytes outside an active blit are dropped
                    if (row_reg < blit_height_reg)
                    begin
                        s1_next.valid    = 1'b1;
                        s1_next.op       = OP_WRITE;
                        s1_next.data     = invert_reg ? ~src_byte : src_byte;
                        s1_next.col_byte = col_byte_reg;
                        s1_next.row      = row_reg;
                        s1_next.done     = 1'b0;
                        if (({1'b0, col_byte_reg} + 9'd1) >= {1'b0, pitch_reg})
                        begin
                            col_byte_next = 8'd0;
                            row_next      = row_reg + 10'd1;
                            s1_next.done  = (({1'b0, row_reg} + 11'd1)
                                             >= {1'b0, blit_height_reg});
                        end
                        else
                        begin
                            col_byte_next = col_byte_reg + 8'd1;
                        end
                    end
                end
                CMD_READ:
                begin
                    s1_next.valid = 1'b1;
                    s1_next.op    = OP_READ;
                    s1_next.done  = 1'b0;
                    s1_next.addr  = fb_addr;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            blit_width_reg  <= '0;
            blit_height_reg <= '0;
            pitch_reg       <= 8'd1;
            invert_reg      <= 1'b0;
            row_reg         <= '0;
            col_byte_reg    <= '0;
            s1_reg          <= '0;
        end
        else
        begin
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            blit_width_reg  <= blit_width_next;
            blit_height_reg <= blit_height_next;
            pitch_reg       <= pitch_next;
            invert_reg      <= invert_next;
            row_reg         <= row_next;
            col_byte_reg    <= col_byte_next;
            s1_reg          <= s1_next;
        end
    end

    assign geom.origin_x   = origin_x_reg;
    assign geom.origin_y   = origin_y_reg;
    assign geom.blit_width = blit_width_reg;
    assign s1              = s1_reg;

endmodule

FILE: design/mbb_place.sv
// pixel clipping, byte masks and bank addressing, with the merge stage register
module mbb_place #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbb_pkg::blit_geom_t         geom,
    input  mbb_pkg::s1_t                s1,
    output logic [mbb_pkg::BANK_AW-1:0] rd_idx_even,
    output logic [mbb_pkg::BANK_AW-1:0] rd_idx_odd,
    output mbb_pkg::s2_t                s2
);
    import mbb_pkg::*;

    localparam int BPL    = (SCREEN_WIDTH + 7) / 8;
    localparam int LINE_W = 18;

    logic signed [12:0] x0;
    logic signed [11:0] y;
    logic               y_ok;
    logic [7:0]         vm;
    logic [2:0]         shift;
    logic [15:0]        win_mask;
    logic [15:0]        win_data;
    logic signed [9:0]  bc0;
    logic signed [9:0]  bc1;
    logic [LINE_W-1:0]  line_base;
    logic [LINE_W-1:0]  addr0;
    logic [LINE_W-1:0]  addr1;
    logic [7:0]         m0;
    logic [7:0]         m1;
    bank_wr_t           byte0;
    bank_wr_t           byte1;
    s2_t                s2_reg, s2_next;

    always_comb
    begin
        logic [11:0]        col;
        logic signed [12:0] xb;
        x0 = $signed({{2{geom.origin_x[10]}}, geom.origin_x})
           + $signed({2'b00, s1.col_byte, 3'b000});
        y  = $signed({geom.origin_y[10], geom.origin_y}) + $signed({2'b00, s1.row});
        y_ok = (y >= 12'sd0) && (y < $signed(12'(SCREEN_HEIGHT)));
        // one flag per source pixel, msb is the leftmost pixel
        for (int b = 0; b < 8; b++)
        begin
            col = {1'b0, s1.col_byte, 3'b000} + 12'(b);
            xb  = x0 + 13'(b);
            vm[3'(7 - b)] = (col < {2'b00, geom.blit_width}) && !xb[12]
                          && (xb < $signed(13'(SCREEN_WIDTH)));
        end
        shift    = x0[2:0];
        win_mask = {vm, 8'h00} >> shift;
        win_data = {s1.data, 8'h00} >> shift;
        bc0      = x0[12:3];
        bc1      = bc0 + 10'sd1;
        line_base = LINE_W'(y[9:0]) * LINE_W'(BPL);
        addr0    = line_base + {{(LINE_W-8){1'b0}}, bc0[7:0]};
        addr1    = line_base + {{(LINE_W-8){1'b0}}, bc1[7:0]};
        m0       = y_ok ? win_mask[15:8] : 8'h00;
        m1       = y_ok ? win_mask[7:0]  : 8'h00;

        byte0.we   = (m0 != 8'h00) && (addr0 < LINE_W'(STORE_DEPTH));
        byte0.idx  = addr0[ADDR_W-1:1];
        byte0.mask = m0;
        byte0.data = win_data[15:8];
        byte1.we   = (m1 != 8'h00) && (addr1 < LINE_W'(STORE_DEPTH));
        byte1.idx  = addr1[ADDR_W-1:1];
        byte1.mask = m1;
        byte1.data = win_data[7:0];

        s2_next.valid = s1.valid;
        s2_next.op    = s1.op;
        s2_next.done  = s1.done;
        s2_next.rd_bank = s1.addr[0];
        if (s1.op == OP_READ)
        begin
            s2_next.even      = '0;
            s2_next.odd       = '0;
            s2_next.even.idx  = s1.addr[ADDR_W-1:1];
            s2_next.odd.idx   = s1.addr[ADDR_W-1:1];
        end
        else if (addr0[0])
        begin
            // leftmost byte falls in the odd bank
            s2_next.even = byte1;
            s2_next.odd  = byte0;
        end
        else
        begin
            s2_next.even = byte0;
            s2_next.odd  = byte1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign rd_idx_even = s2_next.even.idx;
    assign rd_idx_odd  = s2_next.odd.idx;
    assign s2          = s2_reg;

endmodule

FILE: design/mbb_fifo.sv
// small result queue between the merge stage and the output handshake
module mbb_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  mbb_pkg::result_t            push_data,
    input  logic                        pop,
    output mbb_pkg::result_t            head,
    output logic [mbb_pkg::FIFO_CW-1:0] count
);
    import mbb_pkg::*;

    result_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

FILE: verif/tb_mono_bitmap_clipped_blit_top.sv
// self-checking testbench for the clipped 1 bpp bitmap blit block
`timescale 1ns / 100ps

module tb_mono_bitmap_clipped_blit_top;

    import mbb_pkg::*;

    // screen geometry the block is built with, mirrored by the shadow frame
    localparam int SCR_W       = 128;
    localparam int SCR_H       = 64;
    localparam int LINE_BYTES  = (SCR_W + 7) / 8;
    // cycles after the last result before the block is taken as quiet
    localparam int QUIET_PAD   = 16;
    // long receiver hold-off, long enough to fill the output queue
    localparam int HOLD_CYCLES = 300;
    // cycles with no handshake on either side before the run is called hung;
    // covers the clearing pass and the long hold-off several times
    localparam int STALL_LIMIT = 4000;

    // one command item as offered on the input side; typed is set on table
    // rows whose result is written down directly instead of predicted
    typedef struct {
        cmd_t op;
        int   px;
        int   py;
        int   w;
        int   h;
        int   rb;
        int   fg;
        int   sb;
        int   fa;
        int   typed;
        int   want_data;
        int   want_done;
    } stim_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [9:0]         width;
    logic [9:0]         height;
    logic [7:0]         row_bytes;
    logic               fg_color;
    logic [7:0]         src_byte;
    logic [9:0]         fb_addr;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         read_data;
    logic               blit_done;

    // shadow copy of the framebuffer and the blit state
    logic [7:0]         frame_shadow [0:STORE_DEPTH-1];
    logic signed [10:0] org_x;
    logic signed [10:0] org_y;
    logic [9:0]         blit_w;
    logic [9:0]         blit_h;
    logic [7:0]         pitch;
    logic               invert;
    logic [9:0]         row_at;
    logic [7:0]         colb_at;

    // results still owed by the block, oldest first
    result_t            owed_results [$];

    int                 fail_count;
    int                 items_counted;
    int                 src_gap_pct;
    int                 snk_gap_pct;
    bit                 hold_request;
    bit                 hold_served;
    int                 stall_cycles;

    // directed items: extremes, every command and each corner of the blit
    stim_t dir_tab [26] = '{
        // a cleared framebuffer reads zero at both ends
        '{CMD_READ,  0, 0, 0, 0, 0, 0, 0, 0,       1, 'h00, 0},
        '{CMD_READ,  0, 0, 0, 0, 0, 0, 0, 1023,    1, 'h00, 0},
        // unused command with pos_x at its most negative and every other field at its top, ignored
        '{CMD_NONE,  -1024, 1023, 1023, 1023, 255, 1, 'hFF, 1023, 0, 0, 0},
        // source byte with no blit running, ignored
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hFF, 0,    0, 0, 0},
        // one byte blit at the origin, then read it back
        '{CMD_BEGIN, 0, 0, 8, 1, 1, 1, 0, 0,       0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hA5, 0,    1, 'h00, 1},
        '{CMD_READ,  0, 0, 0, 0, 0, 0, 0, 0,       1, 'hA5, 0},
        // zero height at the most negative corner: stays idle
        '{CMD_BEGIN, -1024, -1024, 0, 0, 255, 0, 0, 0, 0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hFF, 0,    0, 0, 0},
        // fully off screen, widest bitmap cut by a one byte pitch
        '{CMD_BEGIN, 1023, 1023, 1023, 1, 1, 1, 0, 0, 0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hFF, 0,    1, 'h00, 1},
        // inverted blit clipped on the right, padding bits masked
        '{CMD_BEGIN, 124, 62, 10, 2, 2, 0, 0, 0,   0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'h00, 0,    0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hFF, 0,    0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'h5A, 0,    0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'h3C, 0,    0, 0, 0},
        '{CMD_READ,  0, 0, 0, 0, 0, 0, 0, 1007,    0, 0, 0},
        '{CMD_READ,  0, 0, 0, 0, 0, 0, 0, 1023,    0, 0, 0},
        // zero width: bytes are eaten, nothing is written
        '{CMD_BEGIN, -3, -1, 0, 2, 1, 1, 0, 0,     0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hFF, 0,    0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hFF, 0,    1, 'h00, 1},
        // blit abandoned by a new begin, which has a zero pitch
        '{CMD_BEGIN, 4, 4, 16, 5, 2, 1, 0, 0,      0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hFF, 0,    0, 0, 0},
        '{CMD_BEGIN, 8, 0, 3, 1, 0, 1, 0, 0,       0, 0, 0},
        '{CMD_SRC,   0, 0, 0, 0, 0, 0, 'hE0, 0,    0, 0, 0},
        '{CMD_READ,  0, 0, 0, 0, 0, 0, 0, 1,       0, 0, 0}
    };

    mono_bitmap_clipped_blit_top #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .width     (width),
        .height    (height),
        .row_bytes (row_bytes),
        .fg_color  (fg_color),
        .src_byte  (src_byte),
        .fb_addr   (fb_addr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .blit_done (blit_done)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // one pixel into the shadow frame; off-screen pixels are dropped
    function automatic void shadow_plot(input int px, input int py, input logic v);
        int addr;
        if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H)
        begin
            addr = py * LINE_BYTES + px / 8;
            if (addr < STORE_DEPTH)
                frame_shadow[addr][7 - (px % 8)] = v;
        end
    endfunction

    // advance the shadow by one accepted item; returns 1 when a result is due
    function automatic bit shadow_apply(input stim_t it, output result_t res);
        bit   due;
        int   col;
        logic [7:0] pix;
        due = 1'b0;
        res = '0;
        case (it.op)
            CMD_BEGIN:
            begin
                org_x   = 11'(it.px);
                org_y   = 11'(it.py);
                blit_w  = 10'(it.w);
                blit_h  = 10'(it.h);
                pitch   = 8'(it.rb);
                // a zero pitch counts as one byte per row
                if (pitch == 8'd0)
                    pitch = 8'd1;
                invert  = (1'(it.fg) == 1'b0);
                row_at  = '0;
                colb_at = '0;
            end
            CMD_SRC:
            begin
                if (row_at < blit_h)
                begin
                    pix = 8'(it.sb);
                    if (invert)
                        pix = ~pix;
                    for (int b = 0; b < 8; b++)
                    begin
                        col = int'(colb_at) * 8 + b;
                        if (col < int'(blit_w))
                            shadow_plot(int'(org_x) + col, int'(org_y) + int'(row_at),
                                        pix[7 - b]);
                    end
                    colb_at++;
                    if (colb_at >= pitch)
                    begin
                        colb_at = '0;
                        row_at++;
                        if (row_at >= blit_h)
                        begin
                            res.blit_done = 1'b1;
                            due = 1'b1;
                        end
                    end
                end
            end
            CMD_READ:
            begin
                res.read_data = frame_shadow[10'(it.fa)];
                due = 1'b1;
            end
            default: ;
        endcase
        return due;
    endfunction

    // every field random, so unused fields carry noise too
    function automatic stim_t rand_fields();
        stim_t it;
        it.op        = CMD_NONE;
        it.px        = int'($urandom_range(0, 2047)) - 1024;
        it.py        = int'($urandom_range(0, 2047)) - 1024;
        it.w         = $urandom_range(0, 1023);
        it.h         = $urandom_range(0, 1023);
        it.rb        = $urandom_range(0, 255);
        it.fg        = $urandom_range(0, 1);
        it.sb        = $urandom_range(0, 255);
        it.fa        = $urandom_range(0, 1023);
        it.typed     = 0;
        it.want_data = 0;
        it.want_done = 0;
        return it;
    endfunction

    // read item, half of them aimed near the latest blit
    function automatic stim_t read_item();
        stim_t it;
        it = rand_fields();
        it.op = CMD_READ;
        if ($urandom_range(0, 1) == 1)
            it.fa = ((int'(org_y) + int'($urandom_range(0, 7))) & (SCR_H - 1)) * LINE_BYTES
                    + (((int'(org_x) + int'($urandom_range(0, 40))) & (SCR_W - 1)) >> 3);
        return it;
    endfunction

    // offer one item, hold it until taken, then update the shadow
    task automatic send_item(input stim_t it);
        result_t res;
        bit      due;
        if (src_gap_pct != 0 && int'($urandom_range(1, 100)) <= src_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= it.op;
        pos_x     <= 11'(it.px);
        pos_y     <= 11'(it.py);
        width     <= 10'(it.w);
        height    <= 10'(it.h);
        row_bytes <= 8'(it.rb);
        fg_color  <= 1'(it.fg);
        src_byte  <= 8'(it.sb);
        fb_addr   <= 10'(it.fa);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // ignored items do not count toward the run length
        if (!(it.op == CMD_NONE || (it.op == CMD_SRC && row_at >= blit_h)))
            items_counted++;
        due = shadow_apply(it, res);
        if (it.typed != 0)
        begin
            res.read_data = 8'(it.want_data);
            res.blit_done = 1'(it.want_done);
            due = 1'b1;
        end
        if (due)
            owed_results.push_back(res);
    endtask

    // stop offering until every owed result is back, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_PAD) @(posedge clk);
    endtask

    // one blit sequence: begin, source bytes with reads mixed in, some noise
    task automatic random_blit();
        stim_t it;
        int    kind;
        int    nsrc;
        it = rand_fields();
        it.op = CMD_BEGIN;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            // small bitmap around the screen, edges included
            it.px = int'($urandom_range(0, 159)) - 16;
            it.py = int'($urandom_range(0, 79)) - 8;
            it.w  = $urandom_range(0, 40);
            it.h  = $urandom_range(1, 5);
            it.rb = (it.w + 7) / 8;
            if ($urandom_range(0, 3) == 0)
                it.rb = it.rb + int'($urandom_range(0, 2));
            // short pitch, sometimes down to zero
            if ($urandom_range(0, 7) == 0 && it.rb > 0)
                it.rb = it.rb - 1;
        end
        else if (kind == 14)
        begin
            // wide single row, mostly clipped on the right
            it.px = int'($urandom_range(0, 159)) - 16;
            it.py = $urandom_range(0, SCR_H - 1);
            it.w  = $urandom_range(256, 1023);
            it.h  = 1;
            it.rb = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 128)
                                                : $urandom_range(8, 32);
        end
        else if (kind < 18)
        begin
            // begin fields left fully random; long ones get cut short below
        end
        else
        begin
            // degenerate sizes
            if ($urandom_range(0, 1) == 1)
            begin
                it.h = 0;
            end
            else
            begin
                it.w = 0;
                it.h = $urandom_range(1, 3);
            end
            it.rb = $urandom_range(0, 3);
        end
        send_item(it);

        nsrc = it.h * ((8'(it.rb) == 8'd0) ? 1 : int'(8'(it.rb)));
        // huge blits and a share of small ones are abandoned part way
        if (nsrc > 200)
            nsrc = $urandom_range(0, 6);
        else if (kind == 13 && nsrc > 0)
            nsrc = $urandom_range(0, nsrc - 1);

        for (int i = 0; i < nsrc; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                send_item(read_item());
            it = rand_fields();
            it.op = CMD_SRC;
            send_item(it);
        end

        repeat ($urandom_range(0, 2))
            send_item(read_item());
        // stray source byte or unused command
        if ($urandom_range(0, 7) == 0)
        begin
            it = rand_fields();
            it.op = ($urandom_range(0, 1) == 1) ? CMD_SRC : CMD_NONE;
            send_item(it);
        end
    endtask

    // result checker: every accepted result against the oldest owed one
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: read_data %0h blit_done %0b",
                       read_data, blit_done);
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %0h, actual %0h", want.read_data, read_data);
                    fail_count++;
                end
                if (blit_done !== want.blit_done)
                begin
                    $error("blit_done: expected %0b, actual %0b", want.blit_done, blit_done);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        hold_served = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            else if (snk_gap_pct != 0 && int'($urandom_range(1, 100)) <= snk_gap_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // watchdog: too long without a handshake on either side means a hang
    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        fail_count    = 0;
        items_counted = 0;
        src_gap_pct   = 0;
        snk_gap_pct   = 0;
        hold_request  = 1'b0;

        // shadow matches the block's reset state
        for (int a = 0; a < STORE_DEPTH; a++)
            frame_shadow[a] = '0;
        org_x   = '0;
        org_y   = '0;
        blit_w  = '0;
        blit_h  = '0;
        pitch   = 8'd1;
        invert  = 1'b0;
        row_at  = '0;
        colb_at = '0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_NONE;
        pos_x     <= '0;
        pos_y     <= '0;
        width     <= '0;
        height    <= '0;
        row_bytes <= '0;
        fg_color  <= 1'b0;
        src_byte  <= '0;
        fb_addr   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, mild idling on both sides
        src_gap_pct = 20;
        snk_gap_pct = 20;
        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        drain_results();

        // long receiver hold-off while reads keep coming back to back,
        // so the output queue fills and the input stalls
        src_gap_pct  = 0;
        hold_request = 1'b1;
        repeat (24)
            send_item(read_item());

        // random blits in stretches of differing idle rates
        while (items_counted < 640)
        begin
            if (($urandom_range(0, 5) == 0))
            begin
                src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                snk_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            end
            // full pauses mid run: sender waits for every owed result
            if (items_counted >= 330 && items_counted < 345)
                drain_results();
            random_blit();
        end

        // last stretch at full rate on both sides
        src_gap_pct = 0;
        snk_gap_pct = 0;
        while (items_counted < 700)
            random_blit();

        drain_results();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
